// ===== hw/rtl/eanp_pkg.sv =====
// Shared types, constants and check-digit helpers for the EAN/ISBN text parser.
package eanp_pkg;

    localparam int MAIN_DIGITS  = 13;
    localparam int ADDON_DIGITS = 5;
    localparam int MAIN_W       = 4 * MAIN_DIGITS;
    localparam int ADDON_W      = 4 * ADDON_DIGITS;

    typedef logic [3:0] nibble_t;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_START_MODE = 2'd0;
    localparam logic [1:0] REG_SEPARATOR  = 2'd1;
    localparam logic [1:0] REG_ACCEPT_BAD = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE    = 8'd10;
    localparam logic [7:0] CHAR_ZERO       = 8'd48;
    localparam logic [7:0] CHAR_NINE       = 8'd57;
    localparam logic [7:0] CHAR_X_UPPER    = 8'd88;
    localparam logic [7:0] CHAR_X_LOWER    = 8'd120;
    localparam logic [7:0] SEPARATOR_RESET = 8'd43;

    // Weighted sum of the 978 prefix under the 1/3 EAN weights.
    localparam logic [7:0] ISBN_PREFIX_SUM = 8'd38;
    localparam nibble_t    ISBN_X_VALUE    = 4'd10;

    // Result code kinds.
    localparam logic [3:0] KIND_UNKNOWN        = 4'd0;
    localparam logic [3:0] KIND_ISBN_SHORT     = 4'd1;
    localparam logic [3:0] KIND_ISBN_BAD_ADDON = 4'd2;
    localparam logic [3:0] KIND_EAN_BAD_ADDON  = 4'd3;
    localparam logic [3:0] KIND_EAN13          = 4'd4;
    localparam logic [3:0] KIND_ISBN13         = 4'd7;
    localparam logic [3:0] KIND_ISBN10         = 4'd10;

    typedef enum logic [7:0] {
        PH_START    = 8'b0000_0001,
        PH_ISBN_PRE = 8'b0000_0010,
        PH_EAN_PRE  = 8'b0000_0100,
        PH_ISBN13   = 8'b0000_1000,
        PH_EAN13    = 8'b0001_0000,
        PH_ISBN10_A = 8'b0010_0000,
        PH_ISBN13_A = 8'b0100_0000,
        PH_EAN13_A  = 8'b1000_0000
    } phase_t;

    typedef enum logic [1:0] {
        FAM_NONE   = 2'd0,
        FAM_EAN13  = 2'd1,
        FAM_ISBN13 = 2'd2,
        FAM_ISBN10 = 2'd3
    } fam_t;

    typedef enum logic [1:0] {
        ADD_NONE = 2'd0,
        ADD_TWO  = 2'd1,
        ADD_FIVE = 2'd2
    } add_t;

    typedef struct packed {
        logic       start_mode;
        logic [7:0] separator_char;
        logic       accept_bad_check;
    } cfg_t;

    // One finished line as it travels from the parser to the check stage.
    typedef struct packed {
        fam_t               fam;
        add_t               add;
        logic [3:0]         rej_kind;
        logic               accept_bad;
        logic [MAIN_W-1:0]  main;
        logic [ADDON_W-1:0] addon;
        logic [8:0]         wsum;
        logic [7:0]         asum;
        logic [7:0]         csum;
    } line_rec_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } queue_status_t;

    // Remainder by 11 of a 9-bit value: reciprocal estimate, then one correction.
    function automatic nibble_t mod11(input logic [8:0] x);
        logic [16:0] prod;
        logic [5:0]  q;
        logic [8:0]  qx;
        logic [4:0]  r;
        prod = 17'(x) * 17'd186;
        q    = prod[16:11];
        qx   = 9'(q) * 9'd11;
        r    = 5'(x - qx);
        if (r >= 5'd11)
        begin
            r = r - 5'd11;
        end
        return r[3:0];
    endfunction

    // Remainder by 10 of an 8-bit value.
    function automatic nibble_t mod10(input logic [7:0] x);
        logic [15:0] prod;
        logic [4:0]  q;
        logic [7:0]  qx;
        logic [4:0]  r;
        prod = 16'(x) * 16'd204;
        q    = prod[15:11];
        qx   = 8'(q) * 8'd10;
        r    = 5'(x - qx);
        if (r >= 5'd10)
        begin
            r = r - 5'd10;
        end
        return r[3:0];
    endfunction

    // EAN check digit from the weighted sum of the first twelve digits.
    function automatic nibble_t ean_check(input logic [7:0] sum);
        nibble_t r;
        r = mod10(sum);
        return (r == 4'd0) ? 4'd0 : 4'(4'd10 - r);
    endfunction

endpackage

// ===== hw/rtl/eanp_if.sv =====
// Stream interfaces for text words in and parse results out.
interface eanp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
    modport monitor (input valid, input ready, input text_byte);
endinterface

interface eanp_result_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        check_ok;
    logic [3:0]  code_kind;
    logic [51:0] main_digits;
    logic [19:0] addon_digits;
    logic [3:0]  check_value;

    modport source (output valid, output accepted, output check_ok, output code_kind,
                    output main_digits, output addon_digits, output check_value,
                    input ready);
    modport sink (input valid, input accepted, input check_ok, input code_kind,
                  input main_digits, input addon_digits, input check_value,
                  output ready);
    modport monitor (input valid, input ready, input accepted, input check_ok,
                     input code_kind, input main_digits, input addon_digits,
                     input check_value);
endinterface

// ===== hw/rtl/ean_isbn_text_parser.sv =====
// Top level of the EAN/ISBN text line parser with check-digit validation.
//
//   channel  | direction | payload                                   | handshake
//   ---------+-----------+-------------------------------------------+-------------
//   text     | in        | text_byte[7:0]                            | valid/ready
//   result   | out       | accepted, check_ok, code_kind, main_digits,| valid/ready
//            |           | addon_digits, check_value                 |
//   wr_*     | in        | wr_index[1:0], wr_data[7:0]               | wr_en only
//
// The parser takes one text word every cycle while the queue is not full; each byte
// updates running sums, so the per-line check work at the newline is combinational
// in the check stage. A newline word is queued at the edge that accepts it; the check
// stage takes it from the queue into the output register when free, raising result.valid.
// Records wait in a two-entry queue; when it is full, text.ready drops.
// A stall on result holds the output register and fills the queue behind it.
// Reset is asynchronous and needs no clearing pass; registers take their reset values.
module ean_isbn_text_parser (
    input  logic           clk,
    input  logic           rst_n,
    eanp_byte_if.sink      text,
    eanp_result_if.source  result,
    input  logic           wr_en,
    input  logic [1:0]     wr_index,
    input  logic [7:0]     wr_data
);

    eanp_pkg::cfg_t           cfg_reg;
    eanp_pkg::queue_status_t  qstat;
    eanp_pkg::line_rec_t      front_rec, head_rec;
    logic                     front_valid, back_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_mode       <= 1'b0;
            cfg_reg.separator_char   <= eanp_pkg::SEPARATOR_RESET;
            cfg_reg.accept_bad_check <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                eanp_pkg::REG_START_MODE: cfg_reg.start_mode       <= wr_data[0];
                eanp_pkg::REG_SEPARATOR:  cfg_reg.separator_char   <= wr_data;
                eanp_pkg::REG_ACCEPT_BAD: cfg_reg.accept_bad_check <= wr_data[0];
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    eanp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .cfg       (cfg_reg),
        .qstat     (qstat),
        .rec_valid (front_valid),
        .rec       (front_rec)
    );

    eanp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_data (front_rec),
        .pop       (back_take),
        .status    (qstat),
        .head      (head_rec)
    );

    eanp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .qstat  (qstat),
        .rec    (head_rec),
        .take   (back_take),
        .result (result)
    );

endmodule

// ===== hw/rtl/eanp_front.sv =====
// Line parser: gathers digits and running check sums, and classifies each line.
module eanp_front (
    input  logic                     clk,
    input  logic                     rst_n,
    eanp_byte_if.sink                text,
    input  eanp_pkg::cfg_t           cfg,
    input  eanp_pkg::queue_status_t  qstat,
    output logic                     rec_valid,
    output eanp_pkg::line_rec_t      rec
);

    eanp_pkg::phase_t  phase_reg, phase_next, phase_eff;
    logic [3:0]        cnt_reg, cnt_next, cnt_p1;
    eanp_pkg::nibble_t digit_reg [eanp_pkg::MAIN_DIGITS];
    eanp_pkg::nibble_t addon_reg [eanp_pkg::ADDON_DIGITS];
    logic [8:0]        wsum_reg, wsum_next;
    logic [7:0]        asum_reg, asum_next;
    logic [7:0]        csum_reg, csum_next;
    logic              ovf_reg, ovf_next;

    logic              accept;
    logic              is_digit, is_x, is_sep, is_nl, is_pre, in_addon;
    logic [7:0]        dsub;
    eanp_pkg::nibble_t dval, main_val;
    logic              main_we, main_put, addon_we;
    logic [7:0]        wterm;
    logic [5:0]        val3;
    eanp_pkg::phase_t  addon_phase;

    assign text.ready = !qstat.full;
    assign accept     = text.valid && text.ready;
    assign rec_valid  = text.valid && is_nl;

    always_comb
    begin
        dsub      = text.text_byte - eanp_pkg::CHAR_ZERO;
        is_digit  = (text.text_byte >= eanp_pkg::CHAR_ZERO) &&
                    (text.text_byte <= eanp_pkg::CHAR_NINE);
        dval      = is_digit ? dsub[3:0] : 4'd0;
        is_x      = (text.text_byte == eanp_pkg::CHAR_X_UPPER) ||
                    (text.text_byte == eanp_pkg::CHAR_X_LOWER);
        is_sep    = (text.text_byte == cfg.separator_char);
        is_nl     = (text.text_byte == eanp_pkg::CHAR_NEWLINE);

        // The code family is chosen at the first word of a line.
        if (phase_reg == eanp_pkg::PH_START)
        begin
            phase_eff = cfg.start_mode ? eanp_pkg::PH_ISBN_PRE : eanp_pkg::PH_EAN_PRE;
        end
        else
        begin
            phase_eff = phase_reg;
        end
        is_pre   = (phase_eff == eanp_pkg::PH_ISBN_PRE) || (phase_eff == eanp_pkg::PH_EAN_PRE);
        in_addon = (phase_eff == eanp_pkg::PH_ISBN10_A) ||
                   (phase_eff == eanp_pkg::PH_ISBN13_A) ||
                   (phase_eff == eanp_pkg::PH_EAN13_A);

        phase_next = phase_eff;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        main_we    = 1'b0;
        main_val   = dval;
        addon_we   = 1'b0;

        if (ovf_reg)
        begin
            main_we = 1'b0;
        end
        else if ((phase_eff == eanp_pkg::PH_ISBN_PRE) && is_x && (cnt_reg == 4'd9))
        begin
            main_we  = 1'b1;
            main_val = eanp_pkg::ISBN_X_VALUE;
        end
        else if (is_pre && is_digit && (cnt_reg == 4'd12))
        begin
            main_we    = 1'b1;
            phase_next = (phase_eff == eanp_pkg::PH_ISBN_PRE) ? eanp_pkg::PH_ISBN13
                                                              : eanp_pkg::PH_EAN13;
        end
        else if ((phase_eff == eanp_pkg::PH_ISBN_PRE) && is_sep && (cnt_reg == 4'd10))
        begin
            cnt_next   = 4'd0;
            phase_next = eanp_pkg::PH_ISBN10_A;
        end
        else if (((phase_eff == eanp_pkg::PH_ISBN13) || (phase_eff == eanp_pkg::PH_EAN13)) &&
                 is_sep && (cnt_reg == 4'd13))
        begin
            cnt_next   = 4'd0;
            phase_next = (phase_eff == eanp_pkg::PH_ISBN13) ? eanp_pkg::PH_ISBN13_A
                                                            : eanp_pkg::PH_EAN13_A;
        end
        else if (is_digit)
        begin
            if (in_addon)
            begin
                if (cnt_reg < 4'd5)
                begin
                    addon_we = 1'b1;
                    cnt_next = cnt_reg + 4'd1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            else if (is_pre)
            begin
                main_we = 1'b1;
            end
        end

        // Running sums: mod-11 weights i+1, EAN weights 1/3, and the sum of
        // the converted ISBN-13 where digit i lands at position i+3.
        cnt_p1    = cnt_reg + 4'd1;
        main_put  = main_we && (cnt_reg < 4'd13);
        wterm     = {4'd0, main_val} * {4'd0, cnt_p1};
        val3      = {1'b0, main_val, 1'b0} + {2'd0, main_val};
        wsum_next = wsum_reg;
        asum_next = asum_reg;
        csum_next = csum_reg;
        if (main_put)
        begin
            cnt_next = cnt_p1;
            if (cnt_reg < 4'd9)
            begin
                wsum_next = wsum_reg + {1'b0, wterm};
                csum_next = csum_reg + (cnt_reg[0] ? {4'd0, main_val} : {2'd0, val3});
            end
            if (cnt_reg < 4'd12)
            begin
                asum_next = asum_reg + (cnt_reg[0] ? {2'd0, val3} : {4'd0, main_val});
            end
        end
    end

    // End-of-line classification into the record.
    always_comb
    begin
        rec.fam        = eanp_pkg::FAM_NONE;
        rec.add        = eanp_pkg::ADD_NONE;
        rec.rej_kind   = eanp_pkg::KIND_UNKNOWN;
        rec.accept_bad = cfg.accept_bad_check;
        rec.wsum       = wsum_reg;
        rec.asum       = asum_reg;
        rec.csum       = csum_reg;
        for (int i = 0; i < eanp_pkg::MAIN_DIGITS; i++)
        begin
            rec.main[eanp_pkg::MAIN_W - 1 - 4 * i -: 4] = digit_reg[i];
        end
        for (int i = 0; i < eanp_pkg::ADDON_DIGITS; i++)
        begin
            rec.addon[eanp_pkg::ADDON_W - 1 - 4 * i -: 4] = addon_reg[i];
        end

        addon_phase = phase_eff;
        case (phase_eff)
            eanp_pkg::PH_ISBN_PRE:
            begin
                if (cnt_reg == 4'd10)
                begin
                    rec.fam = eanp_pkg::FAM_ISBN10;
                end
                else
                begin
                    rec.rej_kind = eanp_pkg::KIND_ISBN_SHORT;
                end
            end
            eanp_pkg::PH_ISBN13:
            begin
                rec.fam = eanp_pkg::FAM_ISBN13;
            end
            eanp_pkg::PH_EAN13:
            begin
                rec.fam = eanp_pkg::FAM_EAN13;
            end
            eanp_pkg::PH_ISBN10_A, eanp_pkg::PH_ISBN13_A, eanp_pkg::PH_EAN13_A:
            begin
                if (ovf_reg)
                begin
                    rec.rej_kind = eanp_pkg::KIND_UNKNOWN;
                end
                else if (cnt_reg == 4'd2 || cnt_reg == 4'd5 || cnt_reg == 4'd0)
                begin
                    case (addon_phase)
                        eanp_pkg::PH_ISBN10_A: rec.fam = eanp_pkg::FAM_ISBN10;
                        eanp_pkg::PH_ISBN13_A: rec.fam = eanp_pkg::FAM_ISBN13;
                        default:               rec.fam = eanp_pkg::FAM_EAN13;
                    endcase
                    if (cnt_reg == 4'd2)
                    begin
                        rec.add = eanp_pkg::ADD_TWO;
                    end
                    else if (cnt_reg == 4'd5)
                    begin
                        rec.add = eanp_pkg::ADD_FIVE;
                    end
                end
                else if (cnt_reg inside {4'd3, 4'd4})
                begin
                    rec.rej_kind = (phase_eff == eanp_pkg::PH_EAN13_A)
                                 ? eanp_pkg::KIND_EAN_BAD_ADDON
                                 : eanp_pkg::KIND_ISBN_BAD_ADDON;
                end
            end
            default:
            begin
                rec.fam = eanp_pkg::FAM_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= eanp_pkg::PH_START;
            cnt_reg   <= 4'd0;
            wsum_reg  <= 9'd0;
            asum_reg  <= 8'd0;
            csum_reg  <= eanp_pkg::ISBN_PREFIX_SUM;
            ovf_reg   <= 1'b0;
            for (int i = 0; i < eanp_pkg::MAIN_DIGITS; i++)
            begin
                digit_reg[i] <= 4'd0;
            end
            for (int i = 0; i < eanp_pkg::ADDON_DIGITS; i++)
            begin
                addon_reg[i] <= 4'd0;
            end
        end
        else if (accept)
        begin
            if (is_nl)
            begin
                phase_reg <= eanp_pkg::PH_START;
                cnt_reg   <= 4'd0;
                wsum_reg  <= 9'd0;
                asum_reg  <= 8'd0;
                csum_reg  <= eanp_pkg::ISBN_PREFIX_SUM;
                ovf_reg   <= 1'b0;
                for (int i = 0; i < eanp_pkg::MAIN_DIGITS; i++)
                begin
                    digit_reg[i] <= 4'd0;
                end
                for (int i = 0; i < eanp_pkg::ADDON_DIGITS; i++)
                begin
                    addon_reg[i] <= 4'd0;
                end
            end
            else
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                wsum_reg  <= wsum_next;
                asum_reg  <= asum_next;
                csum_reg  <= csum_next;
                ovf_reg   <= ovf_next;
                if (main_put)
                begin
                    digit_reg[cnt_reg] <= main_val;
                end
                if (addon_we)
                begin
                    addon_reg[cnt_reg[2:0]] <= dval;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/eanp_queue.sv =====
// Two-entry queue of finished line records between the parser and the check stage.
module eanp_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  eanp_pkg::line_rec_t      push_data,
    input  logic                     pop,
    output eanp_pkg::queue_status_t  status,
    output eanp_pkg::line_rec_t      head
);

    eanp_pkg::line_rec_t entry_reg [2];
    logic                wr_ptr_reg, rd_ptr_reg;
    logic [1:0]          count_reg, count_next;
    logic                do_push, do_pop;

    assign status.full       = (count_reg == 2'd2);
    assign status.head_valid = (count_reg != 2'd0);
    assign head              = entry_reg[rd_ptr_reg];
    assign do_push           = push && !status.full;
    assign do_pop            = pop && status.head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/eanp_back.sv =====
// Check stage: computes check digits, converts ISBN-10 and registers the result.
module eanp_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  eanp_pkg::queue_status_t  qstat,
    input  eanp_pkg::line_rec_t      rec,
    output logic                     take,
    eanp_result_if.source            result
);

    logic              valid_reg;
    logic              acc_next, ok_next;
    logic [3:0]        kind_next;
    logic [51:0]       main_next;
    eanp_pkg::nibble_t chk_next;
    eanp_pkg::nibble_t chk11, chk_conv, chk_main;
    eanp_pkg::nibble_t digit9, digit12;
    logic [3:0]        add_amt;

    assign take         = qstat.head_valid && (!valid_reg || result.ready);
    assign result.valid = valid_reg;

    always_comb
    begin
        chk11    = eanp_pkg::mod11(rec.wsum);
        chk_conv = eanp_pkg::ean_check(rec.csum);
        chk_main = eanp_pkg::ean_check(rec.asum);
        digit9   = rec.main[15:12];
        digit12  = rec.main[3:0];
        add_amt  = {2'd0, rec.add};

        acc_next  = 1'b0;
        ok_next   = 1'b0;
        kind_next = rec.rej_kind;
        main_next = rec.main;
        chk_next  = 4'd0;

        case (rec.fam)
            eanp_pkg::FAM_ISBN10:
            begin
                ok_next = (digit9 == chk11);
                if (ok_next)
                begin
                    // 978 prefix, first nine digits, fresh check digit.
                    main_next = {4'd9, 4'd7, 4'd8, rec.main[51:16], chk_conv};
                    chk_next  = chk_conv;
                    kind_next = eanp_pkg::KIND_ISBN13 + add_amt;
                end
                else
                begin
                    chk_next  = chk11;
                    kind_next = eanp_pkg::KIND_ISBN10 + add_amt;
                end
                acc_next = ok_next || rec.accept_bad;
            end
            eanp_pkg::FAM_ISBN13, eanp_pkg::FAM_EAN13:
            begin
                chk_next  = chk_main;
                ok_next   = (digit12 == chk_main);
                kind_next = ((rec.fam == eanp_pkg::FAM_ISBN13) ? eanp_pkg::KIND_ISBN13
                                                               : eanp_pkg::KIND_EAN13) + add_amt;
                acc_next  = ok_next || rec.accept_bad;
            end
            default:
            begin
                acc_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result.accepted     <= acc_next;
            result.check_ok     <= ok_next;
            result.code_kind    <= kind_next;
            result.main_digits  <= main_next;
            result.addon_digits <= rec.addon;
            result.check_value  <= chk_next;
        end
    end

endmodule

// ===== hw/rtl/eanp_checker.sv =====
// Port-level checks of the parser's result stream, bound to the top level.
module eanp_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        result_valid,
    input  logic                        result_ready,
    input  logic                        accepted,
    input  logic                        check_ok,
    input  logic [3:0]                  code_kind,
    input  logic [eanp_pkg::MAIN_W-1:0] main_digits,
    input  logic [3:0]                  check_value
);

    // A result word stays offered until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result word dropped while stalled");

    a_accept_family: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && accepted |-> code_kind >= eanp_pkg::KIND_EAN13)
        else $error("rejected kind reported as accepted");

    a_reject_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (code_kind < eanp_pkg::KIND_EAN13) |->
            !accepted && !check_ok && (check_value == 4'd0))
        else $error("rejected line carries check information");

    // A passing 13-digit code ends in the computed check digit.
    a_check_digit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && check_ok && (code_kind >= eanp_pkg::KIND_EAN13) &&
        (code_kind < eanp_pkg::KIND_ISBN10) |->
            main_digits[3:0] == check_value)
        else $error("main digits do not end in the check digit");

    // An ISBN-10 kind only survives a failed check and keeps ten digits.
    a_isbn10_kept: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (code_kind >= eanp_pkg::KIND_ISBN10) |->
            !check_ok && (main_digits[11:0] == 12'd0))
        else $error("unconverted ISBN-10 result is inconsistent");

endmodule

bind ean_isbn_text_parser eanp_checker u_eanp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .accepted     (result.accepted),
    .check_ok     (result.check_ok),
    .code_kind    (result.code_kind),
    .main_digits  (result.main_digits),
    .check_value  (result.check_value)
);

// ===== bench/ean_isbn_text_parser_tb.sv =====
// Self-checking testbench for the EAN/ISBN text line parser with a built-in line predictor.
module ean_isbn_text_parser_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 1600;

    typedef struct packed {
        logic                         accepted;
        logic                         check_ok;
        logic [3:0]                   code_kind;
        logic [eanp_pkg::MAIN_W-1:0]  main_digits;
        logic [eanp_pkg::ADDON_W-1:0] addon_digits;
        logic [3:0]                   check_value;
    } line_result_t;

    logic       clk;
    logic       rst_n;
    logic       wr_en;
    logic [1:0] wr_index;
    logic [7:0] wr_data;

    eanp_byte_if   text_ch();
    eanp_result_if result_ch();

    ean_isbn_text_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Predictor copy of the configuration registers.
    logic       cfg_isbn;
    logic [7:0] cfg_sep;
    logic       cfg_accept_bad;

    // Predictor copy of the line state.
    eanp_pkg::phase_t  line_phase;
    eanp_pkg::nibble_t main_nib[eanp_pkg::MAIN_DIGITS];
    eanp_pkg::nibble_t addon_nib[eanp_pkg::ADDON_DIGITS];
    int unsigned       ndig;
    logic [8:0]        wsum;
    logic [7:0]        asum;
    logic              addon_ovf;

    logic [7:0]   text_words[$];
    line_result_t line_results[$];
    int           words_queued;
    int           fail_count;
    int           text_wait;
    int           result_stall;
    logic         text_fire;
    logic         result_fire;
    logic         text_steady;
    logic         result_steady;
    int           quiet_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic int pick_wait(input logic steady);
        return steady ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic clear_line();
        for (int i = 0; i < eanp_pkg::MAIN_DIGITS; i++)
        begin
            main_nib[i] = 4'd0;
        end
        for (int i = 0; i < eanp_pkg::ADDON_DIGITS; i++)
        begin
            addon_nib[i] = 4'd0;
        end
        ndig       = 0;
        line_phase = eanp_pkg::PH_START;
        wsum       = 9'd0;
        asum       = 8'd0;
        addon_ovf  = 1'b0;
    endtask

    task automatic store_main(input eanp_pkg::nibble_t d);
        if (ndig >= eanp_pkg::MAIN_DIGITS)
        begin
            return;
        end
        main_nib[ndig] = d;
        if (ndig < 9)
        begin
            wsum = 9'(wsum + d * (ndig + 1));
        end
        if (ndig < 12)
        begin
            asum = 8'(asum + ((ndig % 2) ? 3 * d : d));
        end
        ndig++;
    endtask

    // Advances the line state by one text word; a newline yields the line's result.
    task automatic parse_text_byte(input logic [7:0] b);
        logic              isdig;
        logic              pre;
        logic              in_addon;
        logic              ok;
        eanp_pkg::nibble_t d;
        eanp_pkg::nibble_t chk;
        eanp_pkg::fam_t    fam;
        eanp_pkg::fam_t    sub;
        eanp_pkg::add_t    add;
        logic [3:0]        kind;
        eanp_pkg::nibble_t fin[eanp_pkg::MAIN_DIGITS];
        int unsigned       s;
        line_result_t      r;
        isdig = (b >= eanp_pkg::CHAR_ZERO && b <= eanp_pkg::CHAR_NINE);
        d     = isdig ? 4'(b - eanp_pkg::CHAR_ZERO) : 4'd0;
        if (line_phase == eanp_pkg::PH_START)
        begin
            line_phase = cfg_isbn ? eanp_pkg::PH_ISBN_PRE : eanp_pkg::PH_EAN_PRE;
        end
        if (b != eanp_pkg::CHAR_NEWLINE)
        begin
            pre      = (line_phase == eanp_pkg::PH_ISBN_PRE ||
                        line_phase == eanp_pkg::PH_EAN_PRE);
            in_addon = (line_phase == eanp_pkg::PH_ISBN10_A ||
                        line_phase == eanp_pkg::PH_ISBN13_A ||
                        line_phase == eanp_pkg::PH_EAN13_A);
            if (addon_ovf)
            begin
                // Everything after an overlong add-on is dropped.
            end
            else if (line_phase == eanp_pkg::PH_ISBN_PRE &&
                     (b == eanp_pkg::CHAR_X_UPPER || b == eanp_pkg::CHAR_X_LOWER) &&
                     ndig == 9)
            begin
                store_main(eanp_pkg::ISBN_X_VALUE);
            end
            else if (pre && isdig && ndig == 12)
            begin
                store_main(d);
                line_phase = (line_phase == eanp_pkg::PH_ISBN_PRE) ? eanp_pkg::PH_ISBN13
                                                                   : eanp_pkg::PH_EAN13;
            end
            else if (line_phase == eanp_pkg::PH_ISBN_PRE && b == cfg_sep && ndig == 10)
            begin
                ndig       = 0;
                line_phase = eanp_pkg::PH_ISBN10_A;
            end
            else if ((line_phase == eanp_pkg::PH_ISBN13 || line_phase == eanp_pkg::PH_EAN13)
                     && b == cfg_sep && ndig == 13)
            begin
                ndig       = 0;
                line_phase = (line_phase == eanp_pkg::PH_ISBN13) ? eanp_pkg::PH_ISBN13_A
                                                                 : eanp_pkg::PH_EAN13_A;
            end
            else if (isdig)
            begin
                if (in_addon)
                begin
                    if (ndig < eanp_pkg::ADDON_DIGITS)
                    begin
                        addon_nib[ndig] = d;
                        ndig++;
                    end
                    else
                    begin
                        addon_ovf = 1'b1;
                    end
                end
                else if (pre)
                begin
                    store_main(d);
                end
            end
            return;
        end

        fam  = eanp_pkg::FAM_NONE;
        add  = eanp_pkg::ADD_NONE;
        kind = eanp_pkg::KIND_UNKNOWN;
        case (line_phase)
            eanp_pkg::PH_ISBN_PRE:
            begin
                if (ndig == 10)
                begin
                    fam = eanp_pkg::FAM_ISBN10;
                end
                else
                begin
                    kind = eanp_pkg::KIND_ISBN_SHORT;
                end
            end
            eanp_pkg::PH_ISBN13: fam = eanp_pkg::FAM_ISBN13;
            eanp_pkg::PH_EAN13:  fam = eanp_pkg::FAM_EAN13;
            eanp_pkg::PH_ISBN10_A, eanp_pkg::PH_ISBN13_A, eanp_pkg::PH_EAN13_A:
            begin
                sub = (line_phase == eanp_pkg::PH_ISBN10_A) ? eanp_pkg::FAM_ISBN10 :
                      (line_phase == eanp_pkg::PH_ISBN13_A) ? eanp_pkg::FAM_ISBN13
                                                            : eanp_pkg::FAM_EAN13;
                if (addon_ovf)
                begin
                    kind = eanp_pkg::KIND_UNKNOWN;
                end
                else if (ndig == 2)
                begin
                    fam = sub;
                    add = eanp_pkg::ADD_TWO;
                end
                else if (ndig == 5)
                begin
                    fam = sub;
                    add = eanp_pkg::ADD_FIVE;
                end
                else if (ndig == 3 || ndig == 4)
                begin
                    kind = (sub == eanp_pkg::FAM_EAN13) ? eanp_pkg::KIND_EAN_BAD_ADDON
                                                        : eanp_pkg::KIND_ISBN_BAD_ADDON;
                end
                else if (ndig == 0)
                begin
                    fam = sub;
                end
            end
            default: ;
        endcase

        for (int i = 0; i < eanp_pkg::MAIN_DIGITS; i++)
        begin
            fin[i] = main_nib[i];
        end
        ok  = 1'b0;
        chk = 4'd0;
        r.accepted = 1'b0;
        if (fam == eanp_pkg::FAM_ISBN10)
        begin
            chk = 4'(wsum % 11);
            ok  = (main_nib[9] == chk);
            if (ok)
            begin
                // Valid ISBN-10 is re-issued under the 978 prefix.
                fin[0] = 4'd9;
                fin[1] = 4'd7;
                fin[2] = 4'd8;
                for (int i = 0; i < 9; i++)
                begin
                    fin[i + 3] = main_nib[i];
                end
                s = 0;
                for (int i = 0; i < 6; i++)
                begin
                    s += fin[2 * i] + 3 * fin[2 * i + 1];
                end
                chk     = 4'((10 - s % 10) % 10);
                fin[12] = chk;
                kind    = eanp_pkg::KIND_ISBN13 + 4'(add);
            end
            else
            begin
                kind = eanp_pkg::KIND_ISBN10 + 4'(add);
            end
            r.accepted = ok | cfg_accept_bad;
        end
        else if (fam != eanp_pkg::FAM_NONE)
        begin
            chk  = 4'((10 - asum % 10) % 10);
            ok   = (main_nib[12] == chk);
            kind = ((fam == eanp_pkg::FAM_EAN13) ? eanp_pkg::KIND_EAN13
                                                 : eanp_pkg::KIND_ISBN13) + 4'(add);
            r.accepted = ok | cfg_accept_bad;
        end

        r.check_ok     = ok;
        r.code_kind    = kind;
        r.check_value  = chk;
        r.main_digits  = '0;
        r.addon_digits = '0;
        for (int i = 0; i < eanp_pkg::MAIN_DIGITS; i++)
        begin
            r.main_digits = {r.main_digits[eanp_pkg::MAIN_W-5:0], fin[i]};
        end
        for (int i = 0; i < eanp_pkg::ADDON_DIGITS; i++)
        begin
            r.addon_digits = {r.addon_digits[eanp_pkg::ADDON_W-5:0], addon_nib[i]};
        end
        line_results.push_back(r);
        clear_line();
    endtask

    // Text side: the word is taken at the rising edge, the next one is offered at the falling.
    always @(posedge clk)
    begin
        text_fire <= rst_n && text_ch.valid && text_ch.ready;
        if (rst_n && text_ch.valid && text_ch.ready)
        begin
            parse_text_byte(text_ch.text_byte);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!text_ch.valid || text_fire))
        begin
            if (text_wait > 0)
            begin
                text_ch.valid <= 1'b0;
                text_wait     <= text_wait - 1;
            end
            else if (text_words.size() > 0)
            begin
                text_ch.valid     <= 1'b1;
                text_ch.text_byte <= text_words.pop_front();
                text_wait         <= pick_wait(text_steady);
            end
            else
            begin
                text_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : result_ready_driver
        int s;
        if (rst_n)
        begin
            s = result_stall;
            if (result_fire)
            begin
                s = pick_wait(result_steady);
            end
            if (s > 0)
            begin
                result_ch.ready <= 1'b0;
                s = s - 1;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
            result_stall <= s;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        line_result_t want;
        result_fire <= rst_n && result_ch.valid && result_ch.ready;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (line_results.size() == 0)
            begin
                report_mismatch("result word with no line pending");
            end
            else
            begin
                want = line_results.pop_front();
                if (result_ch.accepted !== want.accepted)
                begin
                    report_mismatch($sformatf("accepted %b, want %b",
                                              result_ch.accepted, want.accepted));
                end
                if (result_ch.check_ok !== want.check_ok)
                begin
                    report_mismatch($sformatf("check_ok %b, want %b",
                                              result_ch.check_ok, want.check_ok));
                end
                if (result_ch.code_kind !== want.code_kind)
                begin
                    report_mismatch($sformatf("code_kind %0d, want %0d",
                                              result_ch.code_kind, want.code_kind));
                end
                if (result_ch.main_digits !== want.main_digits)
                begin
                    report_mismatch($sformatf("main_digits %h, want %h",
                                              result_ch.main_digits, want.main_digits));
                end
                if (result_ch.addon_digits !== want.addon_digits)
                begin
                    report_mismatch($sformatf("addon_digits %h, want %h",
                                              result_ch.addon_digits, want.addon_digits));
                end
                if (result_ch.check_value !== want.check_value)
                begin
                    report_mismatch($sformatf("check_value %0d, want %0d",
                                              result_ch.check_value, want.check_value));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ean_isbn_text_parser verification failed");
                $finish;
            end
        end
    end

    task automatic push_word(input logic [7:0] w);
        text_words.push_back(w);
        words_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_word(s[i]);
        end
    endtask

    task automatic wait_idle();
        while (text_words.size() != 0 || text_ch.valid || line_results.size() != 0)
        begin
            @(posedge clk);
        end
        // A word that yields no result may still be in the parser.
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        case (idx)
            eanp_pkg::REG_START_MODE: cfg_isbn       = data[0];
            eanp_pkg::REG_SEPARATOR:  cfg_sep        = data;
            eanp_pkg::REG_ACCEPT_BAD: cfg_accept_bad = data[0];
            default: ;
        endcase
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    // Mostly well-formed codes with random content; some noise, wrong lengths and bad checks.
    task automatic add_random_line(input logic close);
        eanp_pkg::nibble_t dg[$];
        int                pick;
        int                n;
        int                s;
        int                alen;
        logic [7:0]        c;
        pick = $urandom_range(0, 9);
        if (!cfg_isbn && pick < 3)
        begin
            pick += 4;
        end
        if (pick <= 3)
        begin
            s = 0;
            for (int i = 0; i < 9; i++)
            begin
                dg.push_back(4'($urandom_range(0, 9)));
                s += dg[i] * (i + 1);
            end
            dg.push_back(($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 10)) : 4'(s % 11));
        end
        else if (pick <= 7)
        begin
            if (cfg_isbn && $urandom_range(0, 3) != 0)
            begin
                dg.push_back(4'd9);
                dg.push_back(4'd7);
                dg.push_back($urandom_range(0, 1) ? 4'd8 : 4'd9);
            end
            while (dg.size() < 12)
            begin
                dg.push_back(4'($urandom_range(0, 9)));
            end
            s = 0;
            for (int i = 0; i < 12; i++)
            begin
                s += (i % 2) ? 3 * dg[i] : dg[i];
            end
            dg.push_back(($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 9))
                                                     : 4'((10 - s % 10) % 10));
        end
        else if (pick == 8)
        begin
            n = $urandom_range(0, 16);
            for (int i = 0; i < n; i++)
            begin
                dg.push_back(4'($urandom_range(0, 9)));
            end
        end
        else
        begin
            n = $urandom_range(0, 20);
            for (int i = 0; i < n; i++)
            begin
                c = 8'($urandom_range(0, 255));
                push_word((c == eanp_pkg::CHAR_NEWLINE) ? 8'hFF : c);
            end
        end

        foreach (dg[i])
        begin
            if (dg[i] == eanp_pkg::ISBN_X_VALUE)
            begin
                push_word($urandom_range(0, 1) ? eanp_pkg::CHAR_X_UPPER
                                               : eanp_pkg::CHAR_X_LOWER);
            end
            else
            begin
                push_word(eanp_pkg::CHAR_ZERO + 8'(dg[i]));
            end
            if ($urandom_range(0, 7) == 0)
            begin
                c = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) == 0 && c != eanp_pkg::CHAR_NEWLINE)
                begin
                    push_word(c);
                end
                else
                begin
                    push_text("-");
                end
            end
        end

        if ($urandom_range(0, 9) >= 5)
        begin
            push_word(cfg_sep);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: alen = 2;
                4, 5, 6:    alen = 5;
                7:          alen = $urandom_range(0, 1);
                8:          alen = $urandom_range(3, 4);
                default:    alen = $urandom_range(6, 8);
            endcase
            for (int i = 0; i < alen; i++)
            begin
                push_word(eanp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
        end
        if (close)
        begin
            push_word(eanp_pkg::CHAR_NEWLINE);
        end
    endtask

    initial
    begin
        int         nlines;
        logic [7:0] sep;
        rst_n             = 1'b0;
        wr_en             = 1'b0;
        wr_index          = eanp_pkg::REG_START_MODE;
        wr_data           = 8'd0;
        text_ch.valid     = 1'b0;
        text_ch.text_byte = 8'd0;
        result_ch.ready   = 1'b0;
        text_fire         = 1'b0;
        result_fire       = 1'b0;
        text_wait         = 0;
        result_stall      = 0;
        text_steady       = 1'b0;
        result_steady     = 1'b0;
        quiet_cycles      = 0;
        fail_count        = 0;
        words_queued      = 0;
        cfg_isbn          = 1'b0;
        cfg_sep           = eanp_pkg::SEPARATOR_RESET;
        cfg_accept_bad    = 1'b0;
        clear_line();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // EAN family at reset settings.
        push_text("4006381333931\n");
        push_text("4006381333932+12\n");
        push_text("9771234567003+12345\n");
        push_text("123\n");
        push_text("\n");
        push_text("4006381333931+123\n");
        push_text("4006381333931+1\n");
        push_text("4006381333931+1234567\n");
        push_text("40063813339311234\n");
        push_text("4006381333931+\n");
        wait_idle();

        write_reg(eanp_pkg::REG_START_MODE, 8'd1);
        write_reg(eanp_pkg::REG_ACCEPT_BAD, 8'd1);
        push_text("0-306-40615-2\n");
        push_text("080442957X+12345\n");
        push_text("080442957x\n");
        push_text("0306406153+12\n");
        push_text("9780306406157+1234\n");
        push_text("12345\n");
        push_text("\n");
        push_word(8'h00);
        push_word(8'hFF);
        push_text("97803064061\n");
        wait_idle();

        // A digit as separator, then a start-mode change in the middle of a line.
        write_reg(eanp_pkg::REG_SEPARATOR, eanp_pkg::CHAR_ZERO + 8'd5);
        write_reg(eanp_pkg::REG_ACCEPT_BAD, 8'd0);
        push_text("0306406152512\n");
        push_text("9785306406157\n");
        push_text("978");
        wait_idle();
        write_reg(eanp_pkg::REG_START_MODE, 8'd0);
        push_text("0306406157\n");
        push_text("4006381333931\n");
        wait_idle();

        words_queued = 0;
        while (words_queued < RANDOM_WORDS)
        begin
            wait_idle();
            if ($urandom_range(0, 9) < 7)
            begin
                write_reg(eanp_pkg::REG_START_MODE, 8'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 6))
                    0, 1:    sep = eanp_pkg::SEPARATOR_RESET;
                    2:       sep = 8'h00;
                    3:       sep = 8'hFF;
                    4:       sep = eanp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
                    5:       sep = 8'd45;
                    default: sep = 8'($urandom_range(0, 255));
                endcase
                write_reg(eanp_pkg::REG_SEPARATOR, sep);
            end
            if ($urandom_range(0, 9) < 7)
            begin
                write_reg(eanp_pkg::REG_ACCEPT_BAD, 8'($urandom_range(0, 1)));
            end
            text_steady   = ($urandom_range(0, 3) == 0);
            result_steady = ($urandom_range(0, 3) == 0);
            nlines = $urandom_range(3, 12);
            for (int k = 0; k < nlines; k++)
            begin
                // Now and then a phase ends in the middle of a line.
                add_random_line(k < nlines - 1 || $urandom_range(0, 9) != 0);
            end
        end
        push_word(eanp_pkg::CHAR_NEWLINE);

        while (text_words.size() != 0 || text_ch.valid || line_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("ean_isbn_text_parser verification clean");
        end
        else
        begin
            $display("ean_isbn_text_parser verification failed");
        end
        $finish;
    end

endmodule
